[src/dpalu_pkg.sv]
// Shared types and constants for the data-processing ALU.
// Request and response payloads, opcode, condition, shift and status codes.
// No dependencies.
package dpalu_pkg;

    // pc reads as the instruction address plus this offset in register-shift forms
    localparam logic [31:0] PC_READ_OFFSET = 32'h0000_0004;
    localparam logic [3:0]  REG_PC         = 4'hF;

    // instruction class field, bits 27:25
    localparam logic [2:0] CLASS_REG = 3'b000;
    localparam logic [2:0] CLASS_IMM = 3'b001;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] first_operand_value;
        logic [31:0] shifted_operand_value;
        logic [31:0] shift_amount_value;
        logic [3:0]  flags_in;
    } t_dp_req;

    typedef struct packed {
        logic [31:0] alu_result;
        logic        write_dest;
        logic [3:0]  flags_out;
        logic [1:0]  exec_status;
        logic        pc_written;
    } t_dp_rsp;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
        OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
        OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
        OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
    } t_dp_op;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
        COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
        COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
        COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
    } t_cond;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef enum logic [1:0] {
        ST_EXECUTED  = 2'd0,
        ST_COND_FAIL = 2'd1,
        ST_UNHANDLED = 2'd2
    } t_exec_status;

endpackage

[src/dpalu_shifter.sv]
// Barrel shifter producing the shifter operand and shifter carry.
// Covers the rotated immediate and the register operand shifted by immediate or register.
// Depends on dpalu_pkg.
module dpalu_shifter (
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_rm,
    input  logic [31:0] i_rs,
    input  logic        i_carry,
    output logic [31:0] o_operand,
    output logic        o_carry
);
    import dpalu_pkg::*;

    logic               imm_form;
    logic               reg_amount;
    t_shift             sh_type;
    logic [7:0]         amt8;
    logic [4:0]         amt5;
    logic [32:0]        lsl_w;
    logic [32:0]        lsr_w;
    logic signed [32:0] asr_w;
    logic [63:0]        ror_t;
    logic [31:0]        ror_w;
    logic [4:0]         rot;
    logic [31:0]        imm32;
    logic [63:0]        imm_t;
    logic               sign;

    // field decode
    assign imm_form   = (i_instruction[27:25] == CLASS_IMM);
    assign reg_amount = i_instruction[4];
    assign sh_type    = t_shift'(i_instruction[6:5]);
    assign amt8       = i_rs[7:0];
    assign amt5       = reg_amount ? i_rs[4:0] : i_instruction[11:7];
    assign sign       = i_rm[31];

    // one shared shifter per direction, carry kept in the extra bit of the non-rotating shifts
    assign lsl_w = {1'b0, i_rm} << amt5;
    assign lsr_w = {i_rm, 1'b0} >> amt5;
    assign asr_w = $signed({i_rm, 1'b0}) >>> amt5;
    assign ror_t = {i_rm, i_rm} >> amt5;
    assign ror_w = ror_t[31:0];

    // rotated 8-bit immediate
    assign rot   = {i_instruction[11:8], 1'b0};
    assign imm32 = {24'h000000, i_instruction[7:0]};
    assign imm_t = {imm32, imm32} >> rot;

    // operand and carry selection with boundary cases
    always_comb begin
        o_operand = i_rm;
        o_carry   = i_carry;
        if (imm_form) begin
            o_operand = imm_t[31:0];
            o_carry   = (rot == 5'd0) ? i_carry : imm_t[31];
        end else if (reg_amount) begin
            if (amt8 != 8'd0) begin
                unique case (sh_type)
                    SH_LSL: begin
                        if (amt8 < 8'd32) begin
                            o_operand = lsl_w[31:0];
                            o_carry   = lsl_w[32];
                        end else begin
                            o_operand = 32'h0;
                            o_carry   = (amt8 == 8'd32) ? i_rm[0] : 1'b0;
                        end
                    end
                    SH_LSR: begin
                        if (amt8 < 8'd32) begin
                            o_operand = lsr_w[32:1];
                            o_carry   = lsr_w[0];
                        end else begin
                            o_operand = 32'h0;
                            o_carry   = (amt8 == 8'd32) ? sign : 1'b0;
                        end
                    end
                    SH_ASR: begin
                        if (amt8 < 8'd32) begin
                            o_operand = asr_w[32:1];
                            o_carry   = asr_w[0];
                        end else begin
                            o_operand = {32{sign}};
                            o_carry   = sign;
                        end
                    end
                    SH_ROR: begin
                        // multiple of 32 leaves the value, carry from the top bit
                        if (amt5 == 5'd0) begin
                            o_operand = i_rm;
                            o_carry   = sign;
                        end else begin
                            o_operand = ror_w;
                            o_carry   = ror_w[31];
                        end
                    end
                    default: begin
                        o_operand = i_rm;
                        o_carry   = i_carry;
                    end
                endcase
            end
        end else begin
            unique case (sh_type)
                SH_LSL: begin
                    if (amt5 != 5'd0) begin
                        o_operand = lsl_w[31:0];
                        o_carry   = lsl_w[32];
                    end
                end
                SH_LSR: begin
                    // zero encodes a shift by 32
                    if (amt5 == 5'd0) begin
                        o_operand = 32'h0;
                        o_carry   = sign;
                    end else begin
                        o_operand = lsr_w[32:1];
                        o_carry   = lsr_w[0];
                    end
                end
                SH_ASR: begin
                    if (amt5 == 5'd0) begin
                        o_operand = {32{sign}};
                        o_carry   = sign;
                    end else begin
                        o_operand = asr_w[32:1];
                        o_carry   = asr_w[0];
                    end
                end
                SH_ROR: begin
                    // zero encodes rotate right extended through carry
                    if (amt5 == 5'd0) begin
                        o_operand = {i_carry, i_rm[31:1]};
                        o_carry   = i_rm[0];
                    end else begin
                        o_operand = ror_w;
                        o_carry   = ror_w[31];
                    end
                end
                default: begin
                    o_operand = i_rm;
                    o_carry   = i_carry;
                end
            endcase
        end
    end

endmodule

[src/dpalu_exec.sv]
// Execute logic for one data-processing instruction: condition check, decode,
// pc operand adjust, ALU and flag update.
// Depends on dpalu_pkg and dpalu_shifter.
module dpalu_exec (
    input  dpalu_pkg::t_dp_req i_req,
    output dpalu_pkg::t_dp_rsp o_rsp
);
    import dpalu_pkg::*;

    logic [31:0]  ins;
    logic [3:0]   fin;
    logic         n_in, z_in, c_in, v_in;
    logic         cond_ok;
    logic [2:0]   cls;
    t_dp_op       op;
    logic         s_bit;
    logic [3:0]   rd;
    logic         unhandled;
    logic         pc_adjust;
    logic [31:0]  rn, rm, rs;
    logic [31:0]  opnd;
    logic         sh_carry;
    logic [31:0]  add_x, add_y;
    logic         add_cin;
    logic [32:0]  sum;
    logic         is_arith;
    logic [31:0]  res;
    logic         writes;
    logic         new_n, new_z, new_c, new_v;

    assign ins   = i_req.instruction;
    assign fin   = i_req.flags_in;
    assign n_in  = fin[3];
    assign z_in  = fin[2];
    assign c_in  = fin[1];
    assign v_in  = fin[0];
    assign cls   = ins[27:25];
    assign op    = t_dp_op'(ins[24:21]);
    assign s_bit = ins[20];
    assign rd    = ins[15:12];

    // condition check, never passes for NV
    always_comb begin
        unique case (t_cond'(ins[31:28]))
            COND_EQ: cond_ok = z_in;
            COND_NE: cond_ok = !z_in;
            COND_CS: cond_ok = c_in;
            COND_CC: cond_ok = !c_in;
            COND_MI: cond_ok = n_in;
            COND_PL: cond_ok = !n_in;
            COND_VS: cond_ok = v_in;
            COND_VC: cond_ok = !v_in;
            COND_HI: cond_ok = c_in && !z_in;
            COND_LS: cond_ok = !c_in || z_in;
            COND_GE: cond_ok = (n_in == v_in);
            COND_LT: cond_ok = (n_in != v_in);
            COND_GT: cond_ok = !z_in && (n_in == v_in);
            COND_LE: cond_ok = z_in || (n_in != v_in);
            COND_AL: cond_ok = 1'b1;
            COND_NV: cond_ok = 1'b0;
            default: cond_ok = 1'b0;
        endcase
    end

    // other instruction classes, multiply/swap/halfword, and status register forms
    assign unhandled = (cls != CLASS_REG && cls != CLASS_IMM)
                    || (cls == CLASS_REG && ins[7] && ins[4])
                    || (!s_bit && ins[24:23] == 2'b10);

    // pc reads ahead in the register-shift form
    assign pc_adjust = (cls == CLASS_REG) && ins[4];
    assign rn = i_req.first_operand_value
              + ((pc_adjust && ins[19:16] == REG_PC) ? PC_READ_OFFSET : 32'h0);
    assign rm = i_req.shifted_operand_value
              + ((pc_adjust && ins[3:0] == REG_PC) ? PC_READ_OFFSET : 32'h0);
    assign rs = i_req.shift_amount_value
              + ((pc_adjust && ins[11:8] == REG_PC) ? PC_READ_OFFSET : 32'h0);

    dpalu_shifter u_shifter (
        .i_instruction (ins),
        .i_rm          (rm),
        .i_rs          (rs),
        .i_carry       (c_in),
        .o_operand     (opnd),
        .o_carry       (sh_carry)
    );

    // adder operands: subtraction as add of the inverted operand
    always_comb begin
        add_x    = rn;
        add_y    = opnd;
        add_cin  = 1'b0;
        is_arith = 1'b1;
        unique case (op)
            OP_ADD, OP_CMN: begin
                add_cin = 1'b0;
            end
            OP_ADC: begin
                add_cin = c_in;
            end
            OP_SUB, OP_CMP: begin
                add_y   = ~opnd;
                add_cin = 1'b1;
            end
            OP_SBC: begin
                add_y   = ~opnd;
                add_cin = c_in;
            end
            OP_RSB: begin
                add_x   = opnd;
                add_y   = ~rn;
                add_cin = 1'b1;
            end
            OP_RSC: begin
                add_x   = opnd;
                add_y   = ~rn;
                add_cin = c_in;
            end
            default: begin
                is_arith = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'h0, add_cin};

    // result select
    always_comb begin
        writes = 1'b1;
        unique case (op)
            OP_AND: res = rn & opnd;
            OP_EOR: res = rn ^ opnd;
            OP_TST: begin
                res    = rn & opnd;
                writes = 1'b0;
            end
            OP_TEQ: begin
                res    = rn ^ opnd;
                writes = 1'b0;
            end
            OP_CMP, OP_CMN: begin
                res    = sum[31:0];
                writes = 1'b0;
            end
            OP_ORR: res = rn | opnd;
            OP_MOV: res = opnd;
            OP_BIC: res = rn & ~opnd;
            OP_MVN: res = ~opnd;
            default: res = sum[31:0];
        endcase
    end

    // flags
    assign new_n = res[31];
    assign new_z = (res == 32'h0);
    assign new_c = is_arith ? sum[32] : sh_carry;
    assign new_v = is_arith ? ((add_x[31] == add_y[31]) && (sum[31] != add_x[31])) : v_in;

    // response assembly
    always_comb begin
        o_rsp.alu_result  = 32'h0;
        o_rsp.write_dest  = 1'b0;
        o_rsp.flags_out   = fin;
        o_rsp.pc_written  = 1'b0;
        o_rsp.exec_status = ST_EXECUTED;
        if (!cond_ok) begin
            o_rsp.exec_status = ST_COND_FAIL;
        end else if (unhandled) begin
            o_rsp.exec_status = ST_UNHANDLED;
        end else begin
            if (s_bit) begin
                o_rsp.flags_out = {new_n, new_z, new_c, new_v};
            end
            if (writes) begin
                o_rsp.alu_result = res;
                o_rsp.write_dest = 1'b1;
                o_rsp.pc_written = (rd == REG_PC);
            end
        end
    end

endmodule

[src/arm_data_processing_alu.sv]
// Data-processing ALU with barrel shifter for 32-bit ARM instructions.
// Pipeline: an accepted request is captured in the input register, executed combinationally,
// and its response is captured in the result register when that register can advance.
// Throughput: one request per cycle while i_rsp_stall is low; set by the single execute pass.
// Reset: synchronous active-low i_rst_n empties both register stages; payloads are not cleared.
// Depends on dpalu_pkg and dpalu_exec.
module arm_data_processing_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_stall,
    input  dpalu_pkg::t_dp_req i_req_data,
    output logic               o_rsp_valid,
    input  logic               i_rsp_stall,
    output dpalu_pkg::t_dp_rsp o_rsp_data
);
    import dpalu_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_dp_req r_in;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_rsp r_out;
    t_dp_rsp exec_rsp;
    logic    out_advance;
    logic    in_accept;

    // execute pass
    dpalu_exec u_exec (
        .i_req (r_in),
        .o_rsp (exec_rsp)
    );

    // pipeline flow control
    assign out_advance = !r_out_valid || !i_rsp_stall;
    assign o_req_stall = r_in_valid && !out_advance;
    assign in_accept   = i_req_valid && !o_req_stall;
    assign n_in_valid  = in_accept || (r_in_valid && !out_advance);
    assign n_out_valid = out_advance ? r_in_valid : r_out_valid;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_req_data;
        end
        if (out_advance && r_in_valid) begin
            r_out <= exec_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;

endmodule

[test/arm_data_processing_alu_test.sv]
// Self-checking testbench for the data-processing ALU: directed and random instruction
// traffic with random back-pressure, each response checked against an in-bench model.
// Depends on dpalu_pkg and the arm_data_processing_alu top level.
module arm_data_processing_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpalu_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_req_valid = 1'b0;
    logic    o_req_stall;
    t_dp_req i_req_data  = '0;
    logic    o_rsp_valid;
    logic    i_rsp_stall = 1'b0;
    t_dp_rsp o_rsp_data;

    t_dp_rsp expected_responses[$];
    int      issued_count   = 0;
    int      checked_count  = 0;
    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    int      stall_left     = 0;
    int      hold_left      = 0;
    logic    quiet_mode     = 1'b0;
    logic    hold_request   = 1'b0;

    arm_data_processing_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req_data  (i_req_data),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp_data  (o_rsp_data)
    );

    initial forever #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model

    function automatic logic condition_passes(logic [3:0] cond_bits, logic [3:0] f);
        logic n = f[3];
        logic z = f[2];
        logic c = f[1];
        logic v = f[0];
        case (t_cond'(cond_bits))
            COND_EQ: return z;
            COND_NE: return !z;
            COND_CS: return c;
            COND_CC: return !c;
            COND_MI: return n;
            COND_PL: return !n;
            COND_VS: return v;
            COND_VC: return !v;
            COND_HI: return c && !z;
            COND_LS: return !c || z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] rotate_right(logic [31:0] v, int unsigned n);
        int unsigned k;
        k = n % 32;
        if (k == 0) return v;
        return (v >> k) | (v << (32 - k));
    endfunction

    // barrel shifter for register operands, returns {carry, value}
    function automatic logic [32:0] shift_operand(logic [31:0] ins, logic [31:0] rm,
                                                  logic [31:0] rs, logic cin);
        t_shift      kind;
        int unsigned amt;
        logic [31:0] value;
        logic        carry;
        kind = t_shift'(ins[6:5]);
        if (ins[4]) begin
            // amount from the low byte of rs
            amt = rs[7:0];
            if (amt == 0) begin
                carry = cin;
                value = rm;
            end else begin
                case (kind)
                    SH_LSL: begin
                        carry = (amt < 32) ? rm[32 - amt] : ((amt == 32) ? rm[0] : 1'b0);
                        value = (amt < 32) ? (rm << amt) : '0;
                    end
                    SH_LSR: begin
                        carry = (amt < 32) ? rm[amt - 1] : ((amt == 32) ? rm[31] : 1'b0);
                        value = (amt < 32) ? (rm >> amt) : '0;
                    end
                    SH_ASR: begin
                        carry = (amt < 32) ? rm[amt - 1] : rm[31];
                        // kept out of a conditional so the shift stays signed
                        if (amt < 32) value = $signed(rm) >>> amt;
                        else value = {32{rm[31]}};
                    end
                    default: begin
                        amt = amt % 32;
                        carry = (amt == 0) ? rm[31] : rm[amt - 1];
                        value = rotate_right(rm, amt);
                    end
                endcase
            end
        end else begin
            // amount from the instruction, zero encodes the wide forms
            amt = ins[11:7];
            case (kind)
                SH_LSL: begin
                    carry = (amt == 0) ? cin : rm[32 - amt];
                    value = rm << amt;
                end
                SH_LSR: begin
                    carry = (amt == 0) ? rm[31] : rm[amt - 1];
                    value = (amt == 0) ? '0 : (rm >> amt);
                end
                SH_ASR: begin
                    carry = (amt == 0) ? rm[31] : rm[amt - 1];
                    if (amt == 0) value = {32{rm[31]}};
                    else value = $signed(rm) >>> amt;
                end
                default: begin
                    carry = (amt == 0) ? rm[0] : rm[amt - 1];
                    value = (amt == 0) ? {cin, rm[31:1]} : rotate_right(rm, amt);
                end
            endcase
        end
        return {carry, value};
    endfunction

    function automatic t_dp_rsp predict_response(t_dp_req req);
        logic [31:0] ins, rn, rm, rs, opnd, res, a, b, t;
        logic [32:0] shifted;
        logic [2:0]  cls;
        logic [4:0]  rot;
        t_dp_op      op;
        logic        cin, scar, s, writes, is_add, is_sub, n, z, c, v;
        t_dp_rsp     rsp;
        ins = req.instruction;
        rn  = req.first_operand_value;
        rm  = req.shifted_operand_value;
        rs  = req.shift_amount_value;
        cin = req.flags_in[1];
        cls = ins[27:25];
        op  = t_dp_op'(ins[24:21]);
        s   = ins[20];
        rsp.alu_result  = '0;
        rsp.write_dest  = 1'b0;
        rsp.flags_out   = req.flags_in;
        rsp.exec_status = ST_EXECUTED;
        rsp.pc_written  = 1'b0;

        if (!condition_passes(ins[31:28], req.flags_in)) begin
            rsp.exec_status = ST_COND_FAIL;
            return rsp;
        end
        // other classes, multiply-like encodings, status moves and branch-exchange
        if ((cls != CLASS_REG && cls != CLASS_IMM) || (cls == CLASS_REG && ins[7] && ins[4]) ||
            (!s && op >= OP_TST && op <= OP_CMN)) begin
            rsp.exec_status = ST_UNHANDLED;
            return rsp;
        end

        // shifter operand
        if (cls == CLASS_IMM) begin
            rot  = {ins[11:8], 1'b0};
            opnd = rotate_right({24'b0, ins[7:0]}, rot);
            scar = (rot == 0) ? cin : opnd[31];
        end else begin
            if (ins[4]) begin
                if (ins[11:8] == REG_PC) rs = rs + PC_READ_OFFSET;
                if (ins[3:0] == REG_PC) rm = rm + PC_READ_OFFSET;
                if (ins[19:16] == REG_PC) rn = rn + PC_READ_OFFSET;
            end
            shifted = shift_operand(ins, rm, rs, cin);
            scar = shifted[32];
            opnd = shifted[31:0];
        end

        // alu
        a = rn;
        b = opnd;
        writes = 1'b1;
        is_add = 1'b0;
        is_sub = 1'b0;
        case (op)
            OP_AND: res = rn & opnd;
            OP_EOR: res = rn ^ opnd;
            OP_SUB: begin res = rn - opnd; is_sub = 1'b1; end
            OP_RSB: begin res = opnd - rn; a = opnd; b = rn; is_sub = 1'b1; end
            OP_ADD: begin res = rn + opnd; is_add = 1'b1; end
            OP_ADC: begin res = rn + opnd + {31'b0, cin}; is_add = 1'b1; end
            OP_SBC: begin res = rn - opnd - {31'b0, ~cin}; is_sub = 1'b1; end
            OP_RSC: begin
                res = opnd - rn - {31'b0, ~cin};
                a = opnd;
                b = rn;
                is_sub = 1'b1;
            end
            OP_TST: begin res = rn & opnd; writes = 1'b0; end
            OP_TEQ: begin res = rn ^ opnd; writes = 1'b0; end
            OP_CMP: begin res = rn - opnd; is_sub = 1'b1; writes = 1'b0; end
            OP_CMN: begin res = rn + opnd; is_add = 1'b1; writes = 1'b0; end
            OP_ORR: res = rn | opnd;
            OP_MOV: res = opnd;
            OP_BIC: res = rn & ~opnd;
            default: res = ~opnd;
        endcase

        // flags
        if (s) begin
            n = res[31];
            z = (res == 0);
            c = scar;
            v = req.flags_in[0];
            if (is_add) begin
                t = (a & b & ~res) | (~a & ~b & res);
                v = t[31];
                t = (a & b) | (a & ~res) | (b & ~res);
                c = t[31];
            end else if (is_sub) begin
                t = (a & ~b & ~res) | (~a & b & res);
                v = t[31];
                t = (a & ~b) | (a & ~res) | (~b & ~res);
                c = t[31];
            end
            rsp.flags_out = {n, z, c, v};
        end

        if (writes) begin
            rsp.alu_result = res;
            rsp.write_dest = 1'b1;
            rsp.pc_written = (ins[15:12] == REG_PC);
        end
        return rsp;
    endfunction

    // ---------------------------------------------------------------- encoding

    function automatic logic [31:0] dp_word(t_cond cond, logic imm, t_dp_op op, logic s,
                                            logic [3:0] rn, logic [3:0] rd, logic [11:0] op2);
        return {cond, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    function automatic logic [11:0] op2_imm(logic [3:0] rot, logic [7:0] imm8);
        return {rot, imm8};
    endfunction

    function automatic logic [11:0] op2_shift_imm(logic [4:0] amt, t_shift sh, logic [3:0] rm);
        return {amt, sh, 1'b0, rm};
    endfunction

    function automatic logic [11:0] op2_shift_reg(logic [3:0] rs, t_shift sh, logic [3:0] rm);
        return {rs, 1'b0, sh, 1'b1, rm};
    endfunction

    // ---------------------------------------------------------------- random content

    // idle length: mostly short, now and then long
    function automatic int pick_idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        return pick_idle_length();
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'($urandom_range(0, 64));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] random_shift_amount();
        case ($urandom_range(0, 6))
            0: return {24'($urandom()), 8'h00};
            1: return 32'd32;
            2: return 32'($urandom_range(1, 31));
            3: return 32'($urandom_range(33, 255));
            4: return {24'($urandom()), 8'($urandom_range(1, 7) * 32)};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [3:0] random_reg();
        if ($urandom_range(0, 7) == 0) return REG_PC;
        return 4'($urandom());
    endfunction

    // mostly well-formed data-processing words, some raw noise
    function automatic t_dp_req random_request();
        t_dp_req     req;
        t_cond       cond;
        t_dp_op      op;
        logic        s;
        logic [11:0] op2;
        logic        imm;
        cond = $urandom_range(0, 1) ? COND_AL : t_cond'($urandom_range(0, 15));
        op   = t_dp_op'($urandom_range(0, 15));
        s    = (op >= OP_TST && op <= OP_CMN) ? ($urandom_range(0, 9) != 0)
                                              : 1'($urandom_range(0, 1));
        imm  = 1'b0;
        case ($urandom_range(0, 2))
            0: begin imm = 1'b1; op2 = 12'($urandom()); end
            1: op2 = op2_shift_imm(5'($urandom()), t_shift'($urandom_range(0, 3)), random_reg());
            default: op2 = op2_shift_reg(random_reg(), t_shift'($urandom_range(0, 3)),
                                         random_reg());
        endcase
        req.instruction = dp_word(cond, imm, op, s, random_reg(), random_reg(), op2);
        if ($urandom_range(0, 99) < 8) req.instruction = $urandom();
        req.first_operand_value   = random_operand();
        req.shifted_operand_value = random_operand();
        req.shift_amount_value    = random_shift_amount();
        req.flags_in              = 4'($urandom());
        return req;
    endfunction

    // ---------------------------------------------------------------- request side

    // offer one request after an optional gap and hold it until accepted
    task automatic issue_instruction(t_dp_req req, int gap);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req_data  <= req;
        do @(posedge i_clk); while (o_req_stall);
        expected_responses.push_back(predict_response(req));
        issued_count++;
    endtask

    task automatic issue_directed(logic [31:0] ins, logic [31:0] rn, logic [31:0] rm,
                                  logic [31:0] rs, logic [3:0] flags);
        t_dp_req req;
        req.instruction           = ins;
        req.first_operand_value   = rn;
        req.shifted_operand_value = rm;
        req.shift_amount_value    = rs;
        req.flags_in              = flags;
        issue_instruction(req, pick_gap());
    endtask

    task automatic wait_for_drain();
        i_req_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        t_dp_req     req;
        logic [11:0] op2;
        // every opcode with flag setting, operands at the extremes
        for (int i = 0; i < 16; i++) begin
            case (i % 3)
                0: op2 = op2_imm(4'(i), 8'hFF);
                1: op2 = op2_shift_imm(5'(i * 2), t_shift'(i % 4), 4'(i));
                default: op2 = op2_shift_reg(4'(i), t_shift'(i % 4), 4'(i));
            endcase
            req.instruction = dp_word(COND_AL, (i % 3 == 0), t_dp_op'(i), 1'b1,
                                      4'(i), 4'(15 - i), op2);
            req.first_operand_value   = i[0] ? 32'hFFFF_FFFF : 32'h8000_0000;
            req.shifted_operand_value = i[1] ? 32'h0000_0000 : 32'h7FFF_FFFF;
            req.shift_amount_value    = i[2] ? 32'd32 : 32'd1;
            req.flags_in              = 4'(i);
            issue_instruction(req, 0);
        end
        // never condition, and a failing equal
        issue_directed(dp_word(COND_NV, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd1,
                               op2_shift_imm(5'd0, SH_LSL, 4'd2)), '1, '1, '1, 4'b0000);
        issue_directed(dp_word(COND_EQ, 1'b0, OP_ADD, 1'b1, 4'd1, 4'd2,
                               op2_shift_imm(5'd3, SH_LSL, 4'd3)), 32'd5, 32'd7, 0, 4'b1011);
        // unhandled: other class, multiply-like encoding, compare without flag setting
        issue_directed({COND_AL, 3'b011, 25'h1AB_CDEF}, 32'd1, 32'd2, 32'd3, 4'b0110);
        issue_directed(dp_word(COND_AL, 1'b0, OP_AND, 1'b0, 4'd1, 4'd2, 12'h091),
                       32'd9, 32'd3, 32'd4, 4'b0000);
        issue_directed(dp_word(COND_AL, 1'b0, OP_TST, 1'b0, 4'd1, 4'd0,
                               op2_shift_imm(5'd0, SH_LSL, 4'd2)), '1, '1, 0, 4'b0100);
        // immediate without rotation keeps carry, largest rotation of 0xff
        issue_directed(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd3, op2_imm(4'd0, 8'h80)),
                       0, 0, 0, 4'b0010);
        issue_directed(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd3, op2_imm(4'd15, 8'hFF)),
                       0, 0, 0, 4'b0000);
        // register rotate by a multiple of 32, and rotate with extend
        issue_directed(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd4,
                               op2_shift_reg(4'd3, SH_ROR, 4'd4)), 0, 32'h8000_0001, 32'd64,
                       4'b0000);
        issue_directed(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd4,
                               op2_shift_imm(5'd0, SH_ROR, 4'd4)), 0, 32'h0000_0001, 0, 4'b0010);
        // logical right by 32 through the zero encoding
        issue_directed(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd5,
                               op2_shift_imm(5'd0, SH_LSR, 4'd6)), 0, 32'h8000_0000, 0, 4'b0000);
        // register amounts of 32, 255 and zero
        issue_directed(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd5,
                               op2_shift_reg(4'd7, SH_LSL, 4'd6)), 0, 32'd1, 32'd32, 4'b0000);
        issue_directed(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd5,
                               op2_shift_reg(4'd7, SH_ASR, 4'd6)), 0, 32'h8000_0000, 32'd255,
                       4'b0000);
        issue_directed(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd5,
                               op2_shift_reg(4'd7, SH_LSR, 4'd6)), 0, 32'hFFFF_FFFF,
                       32'h0000_0100, 4'b0010);
        // pc as every register operand in the register-shift form
        issue_directed(dp_word(COND_AL, 1'b0, OP_ADD, 1'b1, REG_PC, 4'd0,
                               op2_shift_reg(REG_PC, SH_LSL, REG_PC)), 32'hFFFF_FFFC, 32'd8,
                       32'd28, 4'b0000);
        // flag-setting write to the pc
        issue_directed(dp_word(COND_AL, 1'b0, OP_SUB, 1'b1, 4'd1, REG_PC,
                               op2_shift_imm(5'd0, SH_LSL, 4'd2)), 32'd0, 32'd1, 0, 4'b0000);
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++) issue_instruction(random_request(), pick_gap());
    endtask

    task automatic test_back_to_back(int count);
        quiet_mode = 1'b1;
        for (int i = 0; i < count; i++) issue_instruction(random_request(), 0);
        quiet_mode = 1'b0;
    endtask

    // response side holds off while requests keep coming until the input stalls
    task automatic test_receiver_hold(int count);
        hold_request = 1'b1;
        for (int i = 0; i < count; i++) issue_instruction(random_request(), 0);
    endtask

    // bursts separated by a full drain of the pipeline
    task automatic test_sender_drain(int bursts, int count);
        for (int j = 0; j < bursts; j++) begin
            for (int i = 0; i < count; i++) issue_instruction(random_request(), pick_gap());
            wait_for_drain();
        end
    endtask

    // ---------------------------------------------------------------- response side

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_rsp_stall <= 1'b1;
        end else if (quiet_mode) begin
            i_rsp_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_rsp_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_idle_length() - 1;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] expv, logic [31:0] actv);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch in %s at response %0d: expected %h, got %h",
                     what, checked_count, expv, actv);
    endtask

    // compare each accepted response with the oldest prediction
    always @(posedge i_clk) begin
        t_dp_rsp expected;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (expected_responses.size() == 0) begin
                report_mismatch("unexpected response", '0, o_rsp_data.alu_result);
            end else begin
                expected = expected_responses.pop_front();
                if (o_rsp_data.alu_result !== expected.alu_result)
                    report_mismatch("alu_result", expected.alu_result, o_rsp_data.alu_result);
                if (o_rsp_data.write_dest !== expected.write_dest)
                    report_mismatch("write_dest", expected.write_dest, o_rsp_data.write_dest);
                if (o_rsp_data.flags_out !== expected.flags_out)
                    report_mismatch("flags_out", expected.flags_out, o_rsp_data.flags_out);
                if (o_rsp_data.exec_status !== expected.exec_status)
                    report_mismatch("exec_status", expected.exec_status,
                                    o_rsp_data.exec_status);
                if (o_rsp_data.pc_written !== expected.pc_written)
                    report_mismatch("pc_written", expected.pc_written, o_rsp_data.pc_written);
            end
            checked_count++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d responses outstanding",
                     idle_cycles, expected_responses.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(480);
        test_back_to_back(150);
        test_receiver_hold(80);
        test_sender_drain(3, 20);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests: all opcodes and conditions, immediate and register shifts,",
                 issued_count);
        $display("unhandled forms and back-pressure; %0d responses checked, %0d mismatches",
                 checked_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
src/dpalu_pkg.sv
src/dpalu_shifter.sv
src/dpalu_exec.sv
src/arm_data_processing_alu.sv
test/arm_data_processing_alu_test.sv
